// ===== rtl/core/tmsf_pkg.sv =====
package tmsf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CFG_W    = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd10;

    // front-to-back queue, power-of-two depth
    localparam int Q_DEPTH = 2;
    localparam int QAW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;   // item closes the batch
    } t_item;

endpackage

// ===== rtl/core/tmsf_front.sv =====
module tmsf_front #(
    parameter int MAX_SAMPLES = 64,
    parameter int TRIM        = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tmsf_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tmsf_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                           o_item_valid,
    output tmsf_pkg::t_item                o_item,
    input  logic                           i_item_pop
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int EW = (CW > tmsf_pkg::CFG_W) ? CW : tmsf_pkg::CFG_W;
    localparam logic [EW-1:0] MIN_CNT = EW'(2 * TRIM + 1);
    localparam logic [EW-1:0] MAX_CNT = EW'(MAX_SAMPLES);

    logic [tmsf_pkg::CFG_W-1:0] r_cfg;
    logic [CW-1:0]              r_held;
    logic [CW-1:0]              n_held;
    tmsf_pkg::t_item            r_q [tmsf_pkg::Q_DEPTH];
    logic [tmsf_pkg::QAW-1:0]   r_wp;
    logic [tmsf_pkg::QAW-1:0]   r_rp;
    logic [tmsf_pkg::QCW-1:0]   r_cnt;

    logic [EW-1:0] cfg_e;
    logic [EW-1:0] eff_lo;
    logic [EW-1:0] eff;
    logic [EW-1:0] cnt_nx;
    logic          last;
    logic          push;
    logic          pop;

    always_comb begin
        cfg_e  = EW'(r_cfg);
        eff_lo = (cfg_e < MIN_CNT) ? MIN_CNT : cfg_e;
        eff    = (eff_lo > MAX_CNT) ? MAX_CNT : eff_lo;
        cnt_nx = EW'(r_held) + EW'(1);
        last   = (cnt_nx >= eff);
        n_held = last ? '0 : cnt_nx[CW-1:0];
    end

    assign o_ready      = (r_cnt != tmsf_pkg::QCW'(tmsf_pkg::Q_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= tmsf_pkg::CFG_RESET;
            r_held <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (push) begin
                r_held <= n_held;
                r_wp   <= r_wp + tmsf_pkg::QAW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + tmsf_pkg::QAW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + tmsf_pkg::QCW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - tmsf_pkg::QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].sample <= i_sample;
            r_q[r_wp].last   <= last;
        end
    end

endmodule

// ===== rtl/core/tmsf_back.sv =====
module tmsf_back #(
    parameter int MAX_SAMPLES = 64,
    parameter int TRIM        = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_item_valid,
    input  tmsf_pkg::t_item                i_item,
    output logic                           o_item_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tmsf_pkg::SAMPLE_W-1:0]  o_average
);

    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = tmsf_pkg::SAMPLE_W + CW;
    localparam int DCW = $clog2(SW + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_PLACE = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [tmsf_pkg::SAMPLE_W-1:0] r_mem [MAX_SAMPLES];
    logic [tmsf_pkg::SAMPLE_W-1:0] r_rdata;

    logic [2:0]                    r_state, n_state;
    logic [CW-1:0]                 r_held, n_held;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [tmsf_pkg::SAMPLE_W-1:0] r_val, n_val;
    logic                          r_last, n_last;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_hi, n_hi;
    logic [CW-1:0]                 r_kept, n_kept;
    logic                          r_rd_v, n_rd_v;
    logic [SW-1:0]                 r_sum, n_sum;
    logic [SW-1:0]                 r_dq, n_dq;
    logic [CW-1:0]                 r_rem, n_rem;
    logic [DCW-1:0]                r_dcnt, n_dcnt;
    logic                          r_ovalid, n_ovalid;
    logic [tmsf_pkg::SAMPLE_W-1:0] r_odata, n_odata;

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [tmsf_pkg::SAMPLE_W-1:0] wdata;
    logic [AW-1:0]                 raddr;

    logic [CW-1:0]                 cnt;
    logic                          trim_on;
    logic [CW-1:0]                 lo;
    logic [CW-1:0]                 hi;
    logic [CW:0]                   trial;

    always_comb begin
        cnt     = r_held + CW'(1);
        trim_on = (32'(cnt) > 32'(2 * TRIM));
        lo      = trim_on ? CW'(TRIM) : '0;
        hi      = trim_on ? (cnt - CW'(TRIM)) : cnt;
        trial   = {r_rem, r_dq[SW-1]};
    end

    always_comb begin
        n_state    = r_state;
        n_held     = r_held;
        n_pos      = r_pos;
        n_val      = r_val;
        n_last     = r_last;
        n_idx      = r_idx;
        n_hi       = r_hi;
        n_kept     = r_kept;
        n_rd_v     = 1'b0;
        n_sum      = r_sum;
        n_dq       = r_dq;
        n_rem      = r_rem;
        n_dcnt     = r_dcnt;
        n_ovalid   = r_ovalid && !i_ready;
        n_odata    = r_odata;
        we         = 1'b0;
        waddr      = r_pos;
        wdata      = r_val;
        raddr      = r_pos - AW'(1);
        o_item_pop = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_val      = i_item.sample;
                    n_last     = i_item.last;
                    n_pos      = r_held[AW-1:0];
                    raddr      = r_held[AW-1:0] - AW'(1);
                    n_state    = (r_held == '0) ? ST_PLACE : ST_SHIFT;
                end
            end
            ST_SHIFT, ST_PLACE: begin
                if (r_state == ST_SHIFT && r_rdata > r_val) begin
                    we      = 1'b1;
                    wdata   = r_rdata;
                    n_pos   = r_pos - AW'(1);
                    raddr   = r_pos - AW'(2);
                    n_state = (r_pos == AW'(1)) ? ST_PLACE : ST_SHIFT;
                end else begin
                    we = 1'b1;
                    if (r_last) begin
                        n_held  = '0;
                        n_idx   = lo;
                        n_hi    = hi;
                        n_kept  = hi - lo;
                        n_sum   = '0;
                        n_state = ST_SUM;
                    end else begin
                        n_held  = cnt;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SUM: begin
                raddr = r_idx[AW-1:0];
                if (r_rd_v) begin
                    n_sum = r_sum + SW'(r_rdata);
                end
                if (r_idx != r_hi) begin
                    n_idx  = r_idx + CW'(1);
                    n_rd_v = 1'b1;
                end else if (!r_rd_v) begin
                    n_dq    = r_sum;
                    n_rem   = '0;
                    n_dcnt  = DCW'(SW);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_kept}) begin
                    n_rem = CW'(trial - {1'b0, r_kept});
                    n_dq  = {r_dq[SW-2:0], 1'b1};
                end else begin
                    n_rem = trial[CW-1:0];
                    n_dq  = {r_dq[SW-2:0], 1'b0};
                end
                n_dcnt = r_dcnt - DCW'(1);
                if (r_dcnt == DCW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_dq[tmsf_pkg::SAMPLE_W-1:0];
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_held   <= '0;
            r_rd_v   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_rd_v   <= n_rd_v;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_last  <= n_last;
        r_idx   <= n_idx;
        r_hi    <= n_hi;
        r_kept  <= n_kept;
        r_sum   <= n_sum;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_odata <= n_odata;
    end

    assign o_valid   = r_ovalid;
    assign o_average = r_odata;

endmodule

// ===== rtl/core/trimmed_mean_sample_filter_top.sv =====
// Trimmed-mean filter for 12-bit converter samples. Each accepted sample is
// inserted into an ascending buffer; once the batch size (sample_count,
// clamped to 2*TRIM+1..MAX_SAMPLES) is reached, the TRIM lowest and highest
// values are dropped and the floor mean of the rest is sent as one item.
// Samples enter a two-item queue, so the input keeps taking items while the
// sorter works, until the queue is full. Insertion is one buffer move per
// cycle: held entries larger than the sample move up one place. A sample
// that closes a batch then adds a summing pass over the buffer port,
// bit-serial division, and a load of the output register once the last
// result is taken. Write sample_count only when idle.
module trimmed_mean_sample_filter_top #(
    parameter int MAX_SAMPLES = 64,
    parameter int TRIM        = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [6:0]                 i_cfg_wr_data,  // sample_count
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,   // [11:0] sample
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata    // [11:0] average
);

    tmsf_pkg::t_item                item;
    logic                           item_valid;
    logic                           item_pop;
    logic [tmsf_pkg::SAMPLE_W-1:0]  average;

    tmsf_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .TRIM        (TRIM)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_sample      (s_axis_tdata[tmsf_pkg::SAMPLE_W-1:0]),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_item_pop    (item_pop)
    );

    tmsf_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .TRIM        (TRIM)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_average    (average)
    );

    assign m_axis_tdata = {4'b0000, average};

endmodule
